// File: src/assert_macros.svh
// Assertion macros used by the RTL of the life automaton block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold on every clock edge outside reset.
`define LIFE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true on a clock edge outside reset.
`define LIFE_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define LIFE_ASSERT(label, clk, rst_n, prop, msg)
`define LIFE_ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// File: src/life_pkg.sv
// Package with grid geometry, command codes, sequencer states and the cell rule.
package life_pkg;

    localparam int GRID_WIDTH  = 128;
    localparam int GRID_HEIGHT = 64;

    localparam int ROW_W     = $clog2(GRID_HEIGHT);
    localparam int COL_W     = $clog2(GRID_WIDTH);
    localparam int MEM_AW    = ROW_W + 1;
    localparam int MEM_DEPTH = 1 << MEM_AW;

    // A sweep reads rows H-1, 0, 1, ..., H-1, 0: read indexes 0 .. H+1.
    localparam int SWEEP_LAST = GRID_HEIGHT + 1;
    localparam int CNT_W      = $clog2(GRID_HEIGHT + 3);

    localparam int ROW_FW = 6;
    localparam int COL_FW = 7;

    typedef logic [GRID_WIDTH-1:0] row_t;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CELL,
        ST_STEP,
        ST_DONE
    } state_t;

    // Rule B3/S23.
    function automatic logic next_cell(input logic alive, input logic [3:0] nbrs);
        return (nbrs == 4'd3) || (alive && (nbrs == 4'd2));
    endfunction

endpackage

// File: src/life_automaton_torus_step_unit.sv
// Game of life B3/S23 on a toroidal grid: two row-wide stores and a row-sweep sequencer.
// A cell write or read in the grid passes through ST_CELL and ST_DONE; the block is ready again
// after the result is loaded into the output register.
// A step sweeps one row per cycle through the single read port of the grid memory,
// evaluated by one shared row unit.
// Reset clears the sequencer, the output valid flag and the per-row valid bits, so all
// cells read dead and store a is active; no clearing pass is needed.
`include "assert_macros.svh"

module life_automaton_torus_step_unit
    import life_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // row_index[5:0], col_index[12:6], cell_value[13], zero fill
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // read_value[0], zero fill
    output logic [0:0]  m_tuser    // step_done[0]
);

    state_t state_reg, state_next;

    cmd_t             cmd_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic             val_reg;
    logic             active_reg;

    logic [CNT_W-1:0] issue_cnt_reg;
    logic [CNT_W-1:0] q_idx_reg;
    logic             q_vld_reg;
    row_t             up_reg;
    row_t             mid_reg;

    row_t             grid_mem [0:MEM_DEPTH-1];
    row_t             mem_q_reg;
    logic             q_row_vld_reg;
    logic [MEM_DEPTH-1:0] row_valid_reg;

    logic             res_read_reg;
    logic             res_step_reg;
    logic             out_valid_reg;
    logic             out_read_reg;
    logic             out_step_reg;

    logic [ROW_FW-1:0] in_row;
    logic [COL_FW-1:0] in_col;
    logic              in_val;
    cmd_t              in_cmd;
    logic              in_grid;
    logic              accept;

    logic              rd_en;
    logic [MEM_AW-1:0] rd_addr;
    logic              wr_en;
    logic [MEM_AW-1:0] wr_addr;
    row_t              wr_data;

    row_t              q_row;
    row_t              cell_row;
    row_t              next_row;
    logic [ROW_W-1:0]  sweep_row;
    logic              sweep_end;
    logic              out_load;

    assign in_row  = s_tdata[5:0];
    assign in_col  = s_tdata[12:6];
    assign in_val  = s_tdata[13];
    assign in_cmd  = cmd_t'(s_tuser);
    assign in_grid = (32'(in_row) < GRID_HEIGHT) && (32'(in_col) < GRID_WIDTH);
    assign accept  = s_tvalid && s_tready;

    // A row never written since reset reads as all dead.
    assign q_row = q_row_vld_reg ? mem_q_reg : '0;

    always_comb
    begin
        cell_row          = q_row;
        cell_row[col_reg] = val_reg;
    end

    // Read order of the sweep: row H-1 first, then 0 .. H-1, then row 0 again.
    always_comb
    begin
        if (issue_cnt_reg == '0)
            sweep_row = ROW_W'(GRID_HEIGHT - 1);
        else if (issue_cnt_reg == CNT_W'(SWEEP_LAST))
            sweep_row = '0;
        else
            sweep_row = ROW_W'(issue_cnt_reg - CNT_W'(1));
    end

    assign sweep_end = q_vld_reg && (q_idx_reg == CNT_W'(SWEEP_LAST));
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // Shared row unit: one lane per column, rows above, at and below in the window.
    for (genvar c = 0; c < GRID_WIDTH; c++)
    begin : g_lane
        localparam int LF = (c == 0) ? GRID_WIDTH - 1 : c - 1;
        localparam int RT = (c == GRID_WIDTH - 1) ? 0 : c + 1;
        logic [3:0] nbrs;

        assign nbrs = 4'(up_reg[LF]) + 4'(up_reg[c]) + 4'(up_reg[RT])
                    + 4'(mid_reg[LF]) + 4'(mid_reg[RT])
                    + 4'(q_row[LF]) + 4'(q_row[c]) + 4'(q_row[RT]);
        assign next_row[c] = next_cell(mid_reg[c], nbrs);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (in_cmd)
                        CMD_WRITE, CMD_READ: state_next = in_grid ? ST_CELL : ST_DONE;
                        CMD_STEP:            state_next = ST_STEP;
                        default:             state_next = ST_DONE;
                    endcase
                end
            end
            ST_CELL:
                state_next = ST_DONE;
            ST_STEP:
            begin
                if (sweep_end)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Memory port control.
    always_comb
    begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = {active_reg, ROW_W'(in_row)};
        wr_en    = 1'b0;
        wr_addr  = {active_reg, row_reg};
        wr_data  = cell_row;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                rd_en    = s_tvalid;
            end
            ST_CELL:
                wr_en = (cmd_reg == CMD_WRITE);
            ST_STEP:
            begin
                rd_en   = (issue_cnt_reg <= CNT_W'(SWEEP_LAST));
                rd_addr = {active_reg, sweep_row};
                wr_en   = q_vld_reg && (q_idx_reg >= CNT_W'(2));
                wr_addr = {~active_reg, ROW_W'(q_idx_reg - CNT_W'(2))};
                wr_data = next_row;
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            grid_mem[wr_addr] <= wr_data;
        if (rd_en)
            mem_q_reg <= grid_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            q_row_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                row_valid_reg[wr_addr] <= 1'b1;
            if (rd_en)
                q_row_vld_reg <= row_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= 1'b0;
            issue_cnt_reg <= '0;
            q_idx_reg     <= '0;
            q_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            q_vld_reg <= (state_reg == ST_STEP) && rd_en;
            q_idx_reg <= issue_cnt_reg;
            if (state_reg == ST_IDLE)
                issue_cnt_reg <= '0;
            else if ((state_reg == ST_STEP) && rd_en)
                issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
            if ((state_reg == ST_STEP) && sweep_end)
                active_reg <= ~active_reg;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= in_cmd;
            row_reg      <= ROW_W'(in_row);
            col_reg      <= COL_W'(in_col);
            val_reg      <= in_val;
            res_read_reg <= 1'b0;
            res_step_reg <= (in_cmd == CMD_STEP);
        end
        else if ((state_reg == ST_CELL) && (cmd_reg == CMD_READ))
        begin
            res_read_reg <= q_row[col_reg];
        end
        if (q_vld_reg)
        begin
            up_reg  <= mid_reg;
            mid_reg <= q_row;
        end
        if (out_load)
        begin
            out_read_reg <= res_read_reg;
            out_step_reg <= res_step_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_read_reg};
    assign m_tuser  = out_step_reg;

    `LIFE_ASSERT(a_swap_at_sweep_end, clk, rst_n, (state_reg == ST_STEP && sweep_end) |=> (active_reg != $past(active_reg)), "buffers did not swap at end of sweep")
    `LIFE_ASSERT(a_sweep_writes_other, clk, rst_n, (state_reg == ST_STEP && wr_en) |-> (wr_addr[MEM_AW-1] != active_reg), "sweep wrote into the active buffer")
    `LIFE_ASSERT(a_idle_no_sweep_data, clk, rst_n, (state_reg == ST_IDLE) |-> !q_vld_reg, "sweep data pending while idle")
    `LIFE_ASSERT_NEVER(a_result_one_kind, clk, rst_n, m_tvalid && m_tdata[0] && m_tuser[0], "result flags both a read value and a finished step")

endmodule
